>>> rtl/cosine_user_rating_predictor_unit_defines.svh
// Assertion helpers for the rating predictor
`ifndef COSINE_USER_RATING_PREDICTOR_UNIT_DEFINES_SVH
`define COSINE_USER_RATING_PREDICTOR_UNIT_DEFINES_SVH

// implication checked on every clock, disabled in reset
`define CURP_ASSERT_IMP(label, clk, rstn, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
    else $error(msg);

// next-cycle implication
`define CURP_ASSERT_NXT(label, clk, rstn, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

>>> rtl/curp_pkg.sv
`timescale 1ns / 1ps
package curp_pkg;
  localparam int MaxUsers   = 16;
  localparam int MaxItems   = 64;
  localparam int RatingBits = 4;
  localparam int UBits      = $clog2(MaxUsers);
  localparam int IBits      = $clog2(MaxItems);
  localparam int Depth      = MaxUsers * MaxItems;
  localparam int ABits      = UBits + IBits;

  localparam logic       OpWrite = 1'b0;
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNone  = 2'd1;
  localparam logic [1:0] StRated = 2'd2;

  localparam logic [1:0] RegUsers = 2'd0;
  localparam logic [1:0] RegItems = 2'd1;
  localparam logic [1:0] RegThr   = 2'd2;

  localparam logic signed [14:0] PredMax = 15'sd16383;
  localparam logic signed [14:0] PredMin = -15'sd16384;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHK, S_SELF_RD, S_SELF_DIV,
    S_NB_START, S_NB_RD, S_NB_ITEM, S_SQRT, S_SIM_DIV,
    S_MEAN_DIV, S_NB_ADD, S_FIN_DIV, S_FIN, S_OUT
  } state_e;
endpackage

>>> rtl/curp_ram.sv
`timescale 1ns / 1ps
module curp_ram #(
  parameter int Width = 4,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/cosine_user_rating_predictor_unit.sv
`timescale 1ns / 1ps
`include "cosine_user_rating_predictor_unit_defines.svh"
// User-based collaborative-filtering rating predictor with cosine similarity.
// Ratings are written with opcode 0 (one per cycle while idle, no result); a
// query (opcode 1) returns one prediction/status transaction, and no input is
// taken until that result transaction is accepted. A query reads the queried
// user's row once and divides for its mean unless the row is empty, then for
// every other user in use walks both rows through multiply-accumulates, one
// memory read per cycle, a bit-serial square root and a shared 1-bit-a-cycle
// restoring divider for the similarity and the neighbor mean; a last division
// gives the quotient. A query on an entry out of use goes straight to the
// result, one on an entry already rated after its stored rating is read.
// After reset a clearing pass writes all 1024 rating entries to zero, during
// which no item is accepted. Configuration writes are taken at any time but
// belong between queries.
module cosine_user_rating_predictor_unit
  import curp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] opcode, [4:1] user_index, [10:5] item_index, [14:11] rating_value
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [14:0] prediction, [16:15] status
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  // configuration
  logic [4:0]  nusers_q;
  logic [6:0]  nitems_q;
  logic [15:0] thr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nusers_q <= 5'd16;
      nitems_q <= 7'd64;
      thr_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegUsers: nusers_q <= cfg_data_i[4:0];
        RegItems: nitems_q <= cfg_data_i[6:0];
        RegThr:   thr_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [6:0] nu_w, ni_w;
  assign nu_w = (nusers_q > 5'(MaxUsers)) ? 7'(MaxUsers) : {2'b0, nusers_q};
  assign ni_w = (nitems_q > 7'(MaxItems)) ? 7'(MaxItems) : nitems_q;

  // fields
  logic             in_op;
  logic [UBits-1:0] in_u;
  logic [IBits-1:0] in_i;
  logic [3:0]       in_r;
  logic             in_use;
  assign in_op  = s_axis_tdata[0];
  assign in_u   = s_axis_tdata[4:1];
  assign in_i   = s_axis_tdata[10:5];
  assign in_r   = s_axis_tdata[14:11];
  assign in_use = (7'(in_u) < nu_w) && (7'(in_i) < ni_w);

  state_e state_q, state_d;
  logic [ABits-1:0] clr_q, clr_d;
  logic [UBits-1:0] qu_q, qu_d;
  logic [UBits:0]   k_q, k_d;      // neighbor index, reaches MaxUsers
  logic [IBits-1:0] qi_q, qi_d;
  logic [6:0]  cnt_q, cnt_d;       // item counter, one past the last
  logic        rdv_q, rdv_d;       // read data valid for MAC
  logic        rsel_q, rsel_d;     // 0 own row, 1 neighbor row
  logic [RatingBits-1:0] ru_q, ru_d;   // own row rating held for dot product
  logic [15:0] nu2_q, nu2_d;       // own norm^2
  logic [15:0] nk2_q, nk2_d, dot_q, dot_d;
  logic [10:0] sumk_q, sumk_d, sumu_q, sumu_d;
  logic [6:0]  cntk_q, cntk_d, cntu_q, cntu_d;
  logic [RatingBits-1:0] rki_q, rki_d; // neighbor rating at query item
  logic signed [15:0] meanu_q, meanu_d;
  logic [15:0] sim_q, sim_d;
  logic signed [39:0] num_q, num_d;
  logic [19:0] den_q, den_d;
  logic [1:0]  st_q, st_d;
  logic signed [14:0] pred_q, pred_d;
  logic        neg_q, neg_d;
  logic signed [41:0] fin_quo, fin_sum;

  // memory
  logic                  we;
  logic [ABits-1:0]      waddr, raddr;
  logic [RatingBits-1:0] wdata, rdata;
  curp_ram #(.Width(RatingBits), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // shared divider: 48-bit dividend by 32-bit divisor, one bit per cycle
  logic [47:0] dvd_q, dvd_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] rem_q, rem_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic [33:0] rtry;
  logic        dbusy;
  assign dbusy = (dcnt_q != '0);
  assign rtry  = {rem_q, dvd_q[47]} - {2'b0, dvs_q};

  // bit-serial square root of 32-bit operand (16 result bits)
  logic [31:0] sq_n_q, sq_n_d, sq_r_q, sq_r_d, sq_b_q, sq_b_d;

  // multiplier, 17 x 24 signed
  logic signed [16:0] m_a;
  logic signed [23:0] m_b;
  logic signed [40:0] m_p;
  assign m_p = m_a * m_b;

  always_comb begin
    state_d = state_q; clr_d = clr_q; qu_d = qu_q; qi_d = qi_q; k_d = k_q;
    cnt_d = cnt_q; rdv_d = 1'b0; rsel_d = rsel_q; ru_d = ru_q;
    nu2_d = nu2_q; nk2_d = nk2_q; dot_d = dot_q; sumk_d = sumk_q; sumu_d = sumu_q;
    cntk_d = cntk_q; cntu_d = cntu_q; rki_d = rki_q; meanu_d = meanu_q;
    sim_d = sim_q; num_d = num_q; den_d = den_q; st_d = st_q; pred_d = pred_q;
    neg_d = neg_q;
    dvd_d = dvd_q; dvs_d = dvs_q; rem_d = rem_q; dcnt_d = dcnt_q;
    sq_n_d = sq_n_q; sq_r_d = sq_r_q; sq_b_d = sq_b_q;
    we = 1'b0; waddr = clr_q; wdata = '0; raddr = {qu_q, qi_q};
    m_a = '0; m_b = '0;
    fin_quo = '0; fin_sum = '0;
    s_axis_tready = 1'b0;

    if (dbusy) begin
      if (!rtry[33]) begin
        rem_d = rtry[32:0];
        dvd_d = {dvd_q[46:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], dvd_q[47]};
        dvd_d = {dvd_q[46:0], 1'b0};
      end
      dcnt_d = dcnt_q - 6'd1;
    end

    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_q; clr_d = clr_q + ABits'(1);
        if (clr_q == ABits'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_op == OpWrite) begin
            we = in_use;
            waddr = {in_u, in_i}; wdata = in_r[RatingBits-1:0];
          end else begin
            qu_d = in_u; qi_d = in_i; raddr = {in_u, in_i};
            pred_d = '0;
            if (!in_use) begin
              st_d = StNone; state_d = S_OUT;
            end else state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (rdata != '0) begin
          st_d = StRated; state_d = S_OUT;
        end else begin
          nu2_d = '0; sumu_d = '0; cntu_d = '0; cnt_d = '0;
          state_d = S_SELF_RD;
        end
      end
      // own row: norm, sum and count
      S_SELF_RD: begin
        raddr = {qu_q, cnt_q[IBits-1:0]};
        if (cnt_q < ni_w) begin
          rdv_d = 1'b1; cnt_d = cnt_q + 7'd1;
        end
        if (rdv_q) begin
          nu2_d  = nu2_q + 16'(rdata) * 16'(rdata);
          sumu_d = sumu_q + 11'(rdata);
          cntu_d = cntu_q + 7'(rdata != '0);
        end
        if (!(cnt_q < ni_w) && !rdv_q) begin
          if (cntu_q == '0) begin
            meanu_d = '0; state_d = S_NB_START;
          end else begin
            dvd_d = {29'b0, sumu_q, 8'b0}; dvs_d = {25'b0, cntu_q};
            rem_d = '0; dcnt_d = 6'd48;
            state_d = S_SELF_DIV;
          end
        end
      end
      S_SELF_DIV: begin
        if (!dbusy) begin
          meanu_d = $signed(dvd_q[15:0]);
          state_d = S_NB_START;
        end
      end
      S_NB_START: begin
        num_d = '0; den_d = '0; k_d = '0; state_d = S_NB_ITEM;
      end
      S_NB_ITEM: begin
        if (7'(k_q) >= nu_w) begin
          state_d = S_FIN_DIV;
          if (den_q != '0) begin
            neg_d = num_q[39];
            dvd_d = 48'(num_q[39] ? -num_q : num_q);
            dvs_d = {12'b0, den_q}; rem_d = '0; dcnt_d = 6'd48;
          end
        end else if (k_q == {1'b0, qu_q}) begin
          k_d = k_q + (UBits+1)'(1);
        end else begin
          nk2_d = '0; dot_d = '0; sumk_d = '0; cntk_d = '0; cnt_d = '0;
          rsel_d = 1'b0; state_d = S_NB_RD;
        end
      end
      // alternate own and neighbor reads: own rating, then neighbor rating
      S_NB_RD: begin
        raddr = rsel_q ? {k_q[UBits-1:0], cnt_q[IBits-1:0]} : {qu_q, cnt_q[IBits-1:0]};
        if (cnt_q < ni_w) begin
          rdv_d = 1'b1; rsel_d = !rsel_q;
          if (rsel_q) cnt_d = cnt_q + 7'd1;
        end else if (!rdv_q) begin
          state_d = S_SQRT;
          sq_n_d = 32'(nu2_q) * 32'(nk2_q); sq_r_d = '0; sq_b_d = 32'h4000_0000;
        end
        // own rating arrives with rsel_q high, neighbor rating with it low
        if (rdv_q) begin
          if (rsel_q) begin
            ru_d = rdata;
          end else begin
            nk2_d  = nk2_q + 16'(rdata) * 16'(rdata);
            dot_d  = dot_q + 16'(rdata) * 16'(ru_q);
            sumk_d = sumk_q + 11'(rdata);
            cntk_d = cntk_q + 7'(rdata != '0);
            if (cnt_q - 7'd1 == {1'b0, qi_q}) rki_d = rdata;
          end
        end
      end
      S_SQRT: begin
        if (sq_b_q == '0) begin
          state_d = S_SIM_DIV;
          if (nu2_q == '0 || nk2_q == '0 || sq_r_q == '0) begin
            sim_d = '0; state_d = S_MEAN_DIV; dcnt_d = '0;
            if (cntk_q != '0) begin
              dvd_d = {29'b0, sumk_q, 8'b0}; dvs_d = {25'b0, cntk_q};
              rem_d = '0; dcnt_d = 6'd48;
            end
          end else begin
            dvd_d = {17'b0, dot_q, 15'b0}; dvs_d = sq_r_q; rem_d = '0; dcnt_d = 6'd48;
          end
        end else begin
          if (sq_n_q >= sq_r_q + sq_b_q) begin
            sq_n_d = sq_n_q - (sq_r_q + sq_b_q);
            sq_r_d = (sq_r_q >> 1) + sq_b_q;
          end else sq_r_d = sq_r_q >> 1;
          sq_b_d = sq_b_q >> 2;
        end
      end
      S_SIM_DIV: begin
        if (!dbusy) begin
          sim_d = (dvd_q > 48'd32768) ? 16'd32768 : dvd_q[15:0];
          state_d = S_MEAN_DIV;
          dcnt_d = '0;
          if (cntk_q != '0) begin
            dvd_d = {29'b0, sumk_q, 8'b0}; dvs_d = {25'b0, cntk_q};
            rem_d = '0; dcnt_d = 6'd48;
          end
        end
      end
      S_MEAN_DIV: begin
        if (!dbusy) state_d = S_NB_ADD;
      end
      S_NB_ADD: begin
        // deviation uses neighbor mean held in the divider output
        m_a = $signed({1'b0, sim_q});
        m_b = $signed(24'({rki_q, 8'b0}))
            - ((cntk_q == '0) ? 24'sd0 : $signed({8'b0, dvd_q[15:0]}));
        if (sim_q >= thr_q) begin
          num_d = num_q + 40'(m_p);
          den_d = den_q + 20'(sim_q);
        end
        k_d = k_q + (UBits+1)'(1); state_d = S_NB_ITEM;
      end
      S_FIN_DIV: begin
        if (den_q == '0) begin
          st_d = StNone; pred_d = '0; state_d = S_OUT;
        end else if (!dbusy) state_d = S_FIN;
      end
      S_FIN: begin
        // floor toward minus infinity, then saturate
        fin_quo = neg_q ? -$signed({2'b0, dvd_q[39:0]}) - $signed(42'(rem_q != '0))
                        : $signed({2'b0, dvd_q[39:0]});
        fin_sum = fin_quo + 42'(meanu_q);
        if (fin_sum > 42'(PredMax)) pred_d = PredMax;
        else if (fin_sum < 42'(PredMin)) pred_d = PredMin;
        else pred_d = fin_sum[14:0];
        st_d = StOk; state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; dcnt_q <= '0; rdv_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; dcnt_q <= dcnt_d; rdv_q <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qu_q <= qu_d; qi_q <= qi_d; k_q <= k_d; cnt_q <= cnt_d;
    rsel_q <= rsel_d; ru_q <= ru_d; nu2_q <= nu2_d; sumu_q <= sumu_d; cntu_q <= cntu_d;
    meanu_q <= meanu_d; sim_q <= sim_d; num_q <= num_d; den_q <= den_d;
    st_q <= st_d; pred_q <= pred_d; neg_q <= neg_d;
    dvd_q <= dvd_d; dvs_q <= dvs_d; rem_q <= rem_d;
    sq_n_q <= sq_n_d; sq_r_q <= sq_r_d; sq_b_q <= sq_b_d;
    nk2_q <= nk2_d; dot_q <= dot_d; sumk_q <= sumk_d; cntk_q <= cntk_d;
    rki_q <= rki_d;
  end

  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {7'b0, st_q, pred_q};

  `CURP_ASSERT_IMP(a_no_ready_busy, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready,
    "input taken while result pending")
  `CURP_ASSERT_NXT(a_out_done, clk_i, rst_ni, m_axis_tvalid && m_axis_tready,
    !m_axis_tvalid, "result repeated")
  `CURP_ASSERT_IMP(a_pred_zero, clk_i, rst_ni, m_axis_tvalid && (st_q != StOk),
    pred_q == '0, "prediction not zero on failure status")
endmodule

>>> test/cosine_user_rating_predictor_unit_checker.sv
`timescale 1ns / 1ps
module cosine_user_rating_predictor_unit_checker
  import curp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]         status;
    logic signed [14:0] prediction;
  } rating_result_t;

  // local copy of the rating matrix and registers
  logic [RatingBits-1:0] ratings_q [Depth];
  logic [4:0]  users_q;
  logic [6:0]  items_q;
  logic [15:0] thr_q;
  rating_result_t pred_queue [$];

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned rating_at(int u, int i);
    return longint'(ratings_q[u*MaxItems+i]);
  endfunction

  function automatic longint user_mean(int u, int ni);
    longint unsigned sum, cnt;
    sum = 0;
    cnt = 0;
    for (int i = 0; i < ni; i++) begin
      sum += rating_at(u, i);
      if (rating_at(u, i) != 0) cnt++;
    end
    if (cnt == 0) return 0;
    return longint'((sum << 8) / cnt);
  endfunction

  function automatic longint unsigned user_sim(int u, int k, int ni);
    longint unsigned dot, nu, nk, r, s;
    dot = 0;
    nu = 0;
    nk = 0;
    for (int i = 0; i < ni; i++) begin
      dot += rating_at(u, i) * rating_at(k, i);
      nu += rating_at(u, i) * rating_at(u, i);
      nk += rating_at(k, i) * rating_at(k, i);
    end
    if (nu == 0 || nk == 0) return 0;
    r = floor_sqrt(nu * nk);
    if (r == 0) return 0;
    s = (dot << 15) / r;
    return (s > 32768) ? 32768 : s;
  endfunction

  function automatic rating_result_t predict_rating(int u, int item);
    rating_result_t res;
    int nu, ni;
    longint num, den, q, p, dev;
    longint unsigned s;
    nu = (users_q > MaxUsers) ? MaxUsers : users_q;
    ni = (items_q > MaxItems) ? MaxItems : items_q;
    res.prediction = '0;
    num = 0;
    den = 0;
    if (!(u < nu && item < ni)) begin
      res.status = StNone;
      return res;
    end
    if (rating_at(u, item) != 0) begin
      res.status = StRated;
      return res;
    end
    for (int k = 0; k < nu; k++) begin
      if (k == u) continue;
      s = user_sim(u, k, ni);
      if (s >= thr_q) begin
        dev = longint'(rating_at(k, item)) * 256 - user_mean(k, ni);
        num += longint'(s) * dev;
        den += longint'(s);
      end
    end
    if (den == 0) begin
      res.status = StNone;
      return res;
    end
    q = num / den;
    if (num % den != 0 && num < 0) q -= 1;
    p = user_mean(u, ni) + q;
    if (p > 16383) p = 16383;
    if (p < -16384) p = -16384;
    res.prediction = p[14:0];
    res.status = StOk;
    return res;
  endfunction

  // observe configuration, input and result transactions
  always @(posedge clk_i or negedge rst_ni) begin
    rating_result_t want;
    int u, it;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) ratings_q[i] = '0;
      users_q = 5'd16;
      items_q = 7'd64;
      thr_q = '0;
      fail_count_o = 0;
      pred_queue.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegUsers: users_q = cfg_data_i[4:0];
          RegItems: items_q = cfg_data_i[6:0];
          RegThr:   thr_q = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pred_queue.size() == 0) begin
          $error("unexpected result transaction %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = pred_queue.pop_front();
          if (m_axis_tdata[14:0] !== want.prediction) begin
            $error("prediction: expected %0d actual %0d", want.prediction,
                   $signed(m_axis_tdata[14:0]));
            fail_count_o++;
          end
          if (m_axis_tdata[16:15] !== want.status) begin
            $error("status: expected %0d actual %0d", want.status,
                   m_axis_tdata[16:15]);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        u = s_axis_tdata[4:1];
        it = s_axis_tdata[10:5];
        if (s_axis_tdata[0] == OpWrite) begin
          if (u < ((users_q > MaxUsers) ? MaxUsers : users_q) &&
              it < ((items_q > MaxItems) ? MaxItems : items_q))
            ratings_q[u*MaxItems+it] = s_axis_tdata[14:11];
        end else begin
          pred_queue.push_back(predict_rating(u, it));
        end
      end
      pending_o = pred_queue.size();
    end
  end

endmodule

>>> test/cosine_user_rating_predictor_unit_tb.sv
`timescale 1ns / 1ps
module cosine_user_rating_predictor_unit_tb;
  import curp_pkg::*;

  localparam int IdleLimit = 60000;
  // register index outside the list
  localparam logic [1:0] RegSpare = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  int          n_users = 16;
  int          n_items = 64;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cosine_user_rating_predictor_unit dut (.*);

  cosine_user_rating_predictor_unit_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_index_i,
    .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog over cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 9);
  end

  task automatic send_item(bit op, int u, int it, int r);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, r[3:0], it[5:0], u[3:0], op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending != 0) @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[15:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly in-use indexes, occasional out-of-range ones
  task automatic random_item(int qpct);
    int u, it;
    u = ($urandom_range(19) == 0) ? $urandom_range(15) : $urandom_range(n_users - 1);
    it = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(n_items - 1);
    send_item($urandom_range(99) < qpct, u, it, $urandom_range(15));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // small matrix for the directed part
    n_users = 4;
    n_items = 4;
    write_reg(RegUsers, 4);
    write_reg(RegItems, 4);
    write_reg(RegThr, 0);
    send_item(1'b1, 0, 0, 0);   // no neighbour weight on empty matrix
    send_item(1'b0, 0, 0, 15);
    send_item(1'b0, 0, 1, 1);
    send_item(1'b0, 1, 0, 15);
    send_item(1'b0, 1, 2, 15);
    send_item(1'b0, 2, 1, 8);
    send_item(1'b0, 2, 3, 1);
    send_item(1'b0, 3, 3, 15);
    send_item(1'b1, 0, 0, 0);   // entry already rated
    send_item(1'b1, 0, 2, 0);
    send_item(1'b1, 0, 3, 0);
    send_item(1'b1, 1, 1, 0);
    send_item(1'b1, 3, 0, 0);
    send_item(1'b1, 15, 0, 0);  // user out of use
    send_item(1'b1, 0, 63, 0);  // item out of use
    send_item(1'b0, 15, 63, 15); // ignored write
    send_item(1'b1, 2, 0, 0);
    drain_results();
    write_reg(RegThr, 65535);
    send_item(1'b1, 0, 2, 0);
    drain_results();
    write_reg(RegThr, 32768);
    send_item(1'b1, 0, 2, 0);
    send_item(1'b1, 1, 3, 0);
    drain_results();
    write_reg(RegSpare, 5);
    write_reg(RegUsers, 31);    // oversized counts
    write_reg(RegItems, 127);
    write_reg(RegThr, 0);
    n_users = 16;
    n_items = 64;
    send_item(1'b1, 15, 63, 0);
    drain_results();
    write_reg(RegUsers, 0);     // zero counts
    write_reg(RegItems, 0);
    send_item(1'b1, 0, 0, 0);
    send_item(1'b0, 0, 0, 5);
    drain_results();

    // random phases over a range of settings, small sizes mostly
    for (int ph = 0; ph < 8; ph++) begin
      n_users = (ph == 7) ? 16 : $urandom_range(8, 2);
      n_items = (ph == 7) ? 64 : $urandom_range(12, 1);
      write_reg(RegUsers, n_users);
      write_reg(RegItems, n_items);
      write_reg(RegThr, (ph % 3 == 0) ? 0 : $urandom_range(32768));
      calm = (ph == 2);
      for (int k = 0; k < ((ph == 7) ? 20 : 60); k++) random_item(25);
      calm = 1'b0;
      drain_results();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
